// ===== rtl/dual_pointer_region_memory_top_defines.svh =====
// Assertion macros used by the checker module of the region memory.
`ifndef DUAL_POINTER_REGION_MEMORY_TOP_DEFINES_SVH
`define DUAL_POINTER_REGION_MEMORY_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define DPRM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define DPRM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dprm_pkg.sv =====
// Package with the command and outcome codes and the region select mask of the region memory.
`timescale 1ns / 1ps
package dprm_pkg;

	// Access kind carried by the command field
	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_READ  = 1'b1
	} command_t;

	// What an item did
	typedef enum logic [1:0] {
		OUT_ADDR  = 2'd0,
		OUT_STORE = 2'd1,
		OUT_READ  = 2'd2
	} outcome_t;

	// Bits of the address byte that choose a region
	localparam logic [1:0] REGION_SEL_MASK = 2'h3;

endpackage

// ===== rtl/dual_pointer_region_memory_top.sv =====
// Top level of the dual pointer region memory.
`timescale 1ns / 1ps
// done is high in the cycle after the one in which the item is accepted.
// Throughput: one item per cycle while busy is low; the synchronous read port of
// the byte memory registers the read data, and pointers update in the accepting cycle.
// Reset: pointers zero, address expected, all bytes read as zero (per-byte valid
// flags); busy stays high for the first cycle after reset is released.
// The receiver cannot stall: each result shows for exactly one cycle.
module dual_pointer_region_memory_top #(
	parameter int REGION_LEN   = 3,
	parameter int REGION_COUNT = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       command,
	input  logic       channel,
	input  logic [7:0] write_byte,
	output logic       done,
	output logic [7:0] read_byte,
	output logic [1:0] outcome
);

	localparam int DEPTH  = REGION_LEN * REGION_COUNT;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int BASE_W = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
	localparam int OFF_W  = (REGION_LEN > 1) ? $clog2(REGION_LEN) : 1;

	// Reduce a region selector below REGION_COUNT by repeated subtraction
	function automatic logic [BASE_W-1:0] region_of(input logic [1:0] sel);
		logic [4:0] v;
		v = {3'b000, sel};
		for (int k = 0; k < 3; k++) begin
			if (v >= 5'(REGION_COUNT)) begin
				v = v - 5'(REGION_COUNT);
			end
		end
		return BASE_W'(v);
	endfunction

	logic [BASE_W-1:0] base_q   [2];
	logic [OFF_W-1:0]  offset_q [2];
	logic              awaiting_q;
	logic              busy_q;
	logic [DEPTH-1:0]  valid_q;
	logic [7:0]        mem [DEPTH];

	logic              done_s1;
	dprm_pkg::outcome_t outcome_s1;
	logic [7:0]        rdata_s1;
	logic              rvalid_s1;

	logic              accept;
	logic              is_read;
	logic              is_addr;
	logic              is_store;
	logic [IDX_W-1:0]  idx;
	logic [OFF_W:0]    off_inc;
	logic [OFF_W-1:0]  off_next;

	assign accept   = start && !busy_q;
	assign is_read  = (dprm_pkg::command_t'(command) == dprm_pkg::CMD_READ);
	assign is_addr  = !is_read && awaiting_q;
	assign is_store = !is_read && !awaiting_q;

	// Form the byte address of the selected channel and its advanced offset
	always_comb begin
		idx      = IDX_W'(base_q[channel]) * IDX_W'(REGION_LEN) + IDX_W'(offset_q[channel]);
		off_inc  = {1'b0, offset_q[channel]} + (OFF_W+1)'(1);
		off_next = (off_inc >= (OFF_W+1)'(REGION_LEN)) ? '0 : off_inc[OFF_W-1:0];
	end

	// Update channel pointers and the shared address expectation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q[0]   <= '0;
			base_q[1]   <= '0;
			offset_q[0] <= '0;
			offset_q[1] <= '0;
			awaiting_q  <= 1'b1;
			busy_q      <= 1'b1;
		end else begin
			busy_q <= 1'b0;
			if (accept) begin
				if (is_read) begin
					awaiting_q        <= 1'b1;
					offset_q[channel] <= off_next;
				end else if (is_addr) begin
					base_q[channel]   <= region_of(write_byte[1:0] & dprm_pkg::REGION_SEL_MASK);
					offset_q[channel] <= '0;
					awaiting_q        <= 1'b0;
				end else begin
					offset_q[channel] <= off_next;
				end
			end
		end
	end

	// Mark bytes written since reset; unmarked bytes read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (accept && is_store) begin
			valid_q[idx] <= 1'b1;
		end
	end

	// Byte memory: at most one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (accept && is_store) begin
			mem[idx] <= write_byte;
		end
		rdata_s1 <= mem[idx];
	end

	// Result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1     <= 1'b0;
			outcome_s1  <= dprm_pkg::OUT_ADDR;
			rvalid_s1   <= 1'b0;
		end else begin
			done_s1   <= accept;
			rvalid_s1 <= valid_q[idx];
			if (accept) begin
				if (is_read) begin
					outcome_s1 <= dprm_pkg::OUT_READ;
				end else if (is_addr) begin
					outcome_s1 <= dprm_pkg::OUT_ADDR;
				end else begin
					outcome_s1 <= dprm_pkg::OUT_STORE;
				end
			end
		end
	end

	// Drive the result ports; non-read items return zero
	always_comb begin
		busy    = busy_q;
		done    = done_s1;
		outcome = outcome_s1;
		if (outcome_s1 == dprm_pkg::OUT_READ && rvalid_s1) begin
			read_byte = rdata_s1;
		end else begin
			read_byte = 8'h00;
		end
	end

endmodule

// ===== rtl/dprm_checker.sv =====
// Port-level checker of the region memory, bound to the top level.
`timescale 1ns / 1ps
`include "dual_pointer_region_memory_top_defines.svh"
module dprm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       command,
	input logic       channel,
	input logic [7:0] write_byte,
	input logic       done,
	input logic [7:0] read_byte,
	input logic [1:0] outcome
);

	logic accepted;
	logic read_res;
	assign accepted = start && !busy;
	assign read_res = (outcome == dprm_pkg::OUT_READ);

	// Each accepted item yields its result in the next cycle
	`DPRM_ASSERT_NEXT(a_item_done, accepted, done, "accepted item gave no result")
	// No result appears without an item
	`DPRM_ASSERT_NEXT(a_no_spurious, !accepted, !done, "result without an accepted item")
	// A read item reports a read
	`DPRM_ASSERT_NEXT(a_read_outcome, accepted && command, read_res, "read item wrong outcome")
	// Only reads return data
	`DPRM_ASSERT_NOW(a_zero_byte, done && !read_res, read_byte == 8'h00, "non-read result data")

endmodule

bind dual_pointer_region_memory_top dprm_checker u_dprm_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for the dual pointer region memory.
`timescale 1ns / 1ps
module testbench;

	localparam int REGION_LEN   = 3;
	localparam int REGION_COUNT = 4;
	localparam int MEM_BYTES    = REGION_LEN * REGION_COUNT;
	localparam int RANDOM_ITEMS = 1750;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic       command;
	logic       channel;
	logic [7:0] write_byte;
	logic       done;
	logic [7:0] read_byte;
	logic [1:0] outcome;

	int items_sent = 0;

	// One expected result of an access
	typedef struct packed {
		logic [7:0]         data;
		dprm_pkg::outcome_t kind;
	} access_result_t;

	// Mirror of the byte memory and both pointer channels; holds expected results
	class region_access_tracker;
		logic [7:0]     bytes [MEM_BYTES];
		int             base [2];
		int             offset [2];
		bit             awaiting;
		access_result_t pending_results [$];
		int             errors;

		function new();
			foreach (bytes[i]) bytes[i] = 8'h00;
			base[0] = 0;
			base[1] = 0;
			offset[0] = 0;
			offset[1] = 0;
			awaiting = 1'b1;
			errors = 0;
		endfunction

		function int cell_of(logic ch);
			int idx;
			idx = base[ch] * REGION_LEN + offset[ch];
			return (idx < MEM_BYTES) ? idx : 0;
		endfunction

		// Advance the offset, wrapping at the end of the region
		function void step_offset(logic ch);
			offset[ch] = (offset[ch] + 1 >= REGION_LEN) ? 0 : offset[ch] + 1;
		endfunction

		// Predict the result of an accepted item and queue it
		function void note_access(dprm_pkg::command_t cmd, logic ch, logic [7:0] wb);
			access_result_t res;
			res.data = 8'h00;
			if (cmd == dprm_pkg::CMD_READ) begin
				awaiting = 1'b1;
				res.data = bytes[cell_of(ch)];
				step_offset(ch);
				res.kind = dprm_pkg::OUT_READ;
			end else if (awaiting) begin
				base[ch] = int'(wb[1:0] & dprm_pkg::REGION_SEL_MASK) % REGION_COUNT;
				offset[ch] = 0;
				awaiting = 1'b0;
				res.kind = dprm_pkg::OUT_ADDR;
			end else begin
				bytes[cell_of(ch)] = wb;
				step_offset(ch);
				res.kind = dprm_pkg::OUT_STORE;
			end
			pending_results.push_back(res);
		endfunction

		// Compare a strobed result against the oldest expectation
		function void check_result(logic [7:0] rb, logic [1:0] oc);
			access_result_t exp_res;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, read_byte %02h outcome %0d", $time, rb, oc);
				errors++;
				return;
			end
			exp_res = pending_results.pop_front();
			if (rb !== exp_res.data) begin
				$display("%0t: read_byte expected %02h, got %02h", $time, exp_res.data, rb);
				errors++;
			end
			if (oc !== exp_res.kind) begin
				$display("%0t: outcome expected %0d, got %0d", $time, exp_res.kind, oc);
				errors++;
			end
		endfunction

		function void report_leftovers();
			if (pending_results.size() != 0) begin
				$display("%0t: %0d results expected but never seen", $time,
					pending_results.size());
				errors++;
			end
		endfunction
	endclass

	region_access_tracker tracker = new();

	dual_pointer_region_memory_top #(
		.REGION_LEN   (REGION_LEN),
		.REGION_COUNT (REGION_COUNT)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.channel    (channel),
		.write_byte (write_byte),
		.done       (done),
		.read_byte  (read_byte),
		.outcome    (outcome)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Note accepted items before checking results of the same edge
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			tracker.note_access(dprm_pkg::command_t'(command), channel, write_byte);
		if (arst_n && done)
			tracker.check_result(read_byte, outcome);
	end

	// Mostly short gaps, a few long ones; none in a burst
	function automatic int pick_gap(bit burst);
		int r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one item and hold it until accepted; lower start only for a gap
	task automatic send_access(input dprm_pkg::command_t cmd, input logic ch,
			input logic [7:0] wb, input int gap);
		start <= 1'b1;
		command <= cmd;
		channel <= ch;
		write_byte <= wb;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold off until every expected result has come
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic directed_part();
		// Read while an address is awaited: cleared memory, expectation kept
		send_access(dprm_pkg::CMD_READ,  1'b0, 8'h00, pick_gap(0));
		// Latch region 3 and fill it, then wrap the offset
		send_access(dprm_pkg::CMD_WRITE, 1'b0, 8'hFF, pick_gap(0));
		send_access(dprm_pkg::CMD_WRITE, 1'b0, 8'h00, pick_gap(0));
		send_access(dprm_pkg::CMD_WRITE, 1'b0, 8'hFF, pick_gap(0));
		send_access(dprm_pkg::CMD_WRITE, 1'b0, 8'hA5, pick_gap(0));
		send_access(dprm_pkg::CMD_WRITE, 1'b0, 8'h5A, pick_gap(0));
		send_access(dprm_pkg::CMD_READ,  1'b0, 8'hFF, pick_gap(0));
		send_access(dprm_pkg::CMD_READ,  1'b0, 8'h00, pick_gap(0));
		send_access(dprm_pkg::CMD_READ,  1'b0, 8'h00, pick_gap(0));
		// Upper address bits ignored: region 0 on channel 1
		send_access(dprm_pkg::CMD_WRITE, 1'b1, 8'hFC, pick_gap(0));
		send_access(dprm_pkg::CMD_WRITE, 1'b1, 8'h81, pick_gap(0));
		// Shared expectation: channel 0 latches, channel 1 takes the data
		send_access(dprm_pkg::CMD_READ,  1'b1, 8'h00, pick_gap(0));
		send_access(dprm_pkg::CMD_WRITE, 1'b0, 8'h01, pick_gap(0));
		send_access(dprm_pkg::CMD_WRITE, 1'b1, 8'h7E, pick_gap(0));
		send_access(dprm_pkg::CMD_WRITE, 1'b0, 8'h02, pick_gap(0));
		send_access(dprm_pkg::CMD_READ,  1'b1, 8'h00, pick_gap(0));
		send_access(dprm_pkg::CMD_READ,  1'b1, 8'h00, pick_gap(0));
		// Region 2 on channel 1, then a read through channel 0
		send_access(dprm_pkg::CMD_READ,  1'b1, 8'h00, pick_gap(0));
		send_access(dprm_pkg::CMD_WRITE, 1'b1, 8'h56, pick_gap(0));
		send_access(dprm_pkg::CMD_WRITE, 1'b1, 8'hAA, pick_gap(0));
		send_access(dprm_pkg::CMD_READ,  1'b0, 8'h33, pick_gap(0));
		send_access(dprm_pkg::CMD_READ,  1'b1, 8'hCC, pick_gap(0));
	endtask

	task automatic random_part();
		int  stop_at;
		int  n;
		bit  burst;
		bit  paused;
		logic ch;
		stop_at = items_sent + RANDOM_ITEMS;
		paused = 1'b0;
		while (items_sent < stop_at) begin
			burst = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) < 7) begin
				// Well-formed when an address is awaited: address, some data, some reads
				ch = 1'($urandom_range(0, 1));
				send_access(dprm_pkg::CMD_WRITE, ch, 8'($urandom), pick_gap(burst));
				n = $urandom_range(0, 4);
				repeat (n)
					send_access(dprm_pkg::CMD_WRITE, ($urandom_range(0, 7) == 0) ? ~ch : ch,
						8'($urandom), pick_gap(burst));
				n = $urandom_range(0, 4);
				repeat (n)
					send_access(dprm_pkg::CMD_READ, 1'($urandom), 8'($urandom),
						pick_gap(burst));
			end else begin
				// Noise: any mix of accesses
				n = $urandom_range(1, 6);
				repeat (n)
					send_access(dprm_pkg::command_t'($urandom_range(0, 1)), 1'($urandom),
						8'($urandom), pick_gap(burst));
			end
			if (!paused && items_sent >= stop_at - RANDOM_ITEMS / 2) begin
				drain_results();
				paused = 1'b1;
			end
		end
	endtask

	initial begin
		start <= 1'b0;
		command <= 1'b0;
		channel <= 1'b0;
		write_byte <= 8'h00;
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_part();
		random_part();
		drain_results();
		repeat (5) @(posedge clk);
		tracker.report_leftovers();
		if (tracker.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Give up after a generous fixed time
	initial begin
		#5000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
